// ----- rtl/core/rgb222_error_diffusion_dither_assert.svh -----
// assertion macros for the dither rtl
`ifndef RGB222_ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define RGB222_ERROR_DIFFUSION_DITHER_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RGBDITH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgbdith same-cycle check failed");

// next-cycle implication
`define RGBDITH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgbdith next-cycle check failed");

`endif

// ----- rtl/core/rgbdith_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rgbdith_pkg;

    // frame geometry
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int ERR_FRAC_DEF    = 8;
    localparam int MAX_HEIGHT      = 1024;
    localparam int ROW_W           = $clog2(MAX_HEIGHT);
    localparam int FRAME_DIM_W     = 11;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;

    // apb
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // quantizer thresholds on the integer part of the clamped sum
    localparam logic [7:0] LVL_T1 = 8'd43;
    localparam logic [7:0] LVL_T2 = 8'd128;
    localparam logic [7:0] LVL_T3 = 8'd213;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [5:0] palette_index;
        logic       frame_end;
    } t_pix_out;

    function automatic logic [1:0] level_of(input logic [7:0] t);
        logic [1:0] q;
        if (t < LVL_T1) begin
            q = 2'd0;
        end else if (t < LVL_T2) begin
            q = 2'd1;
        end else if (t < LVL_T3) begin
            q = 2'd2;
        end else begin
            q = 2'd3;
        end
        return q;
    endfunction

    // level expanded to 0, 85, 170, 255
    function automatic logic [7:0] level_value(input logic [1:0] q);
        logic [7:0] v;
        case (q)
            2'd0: v = 8'd0;
            2'd1: v = 8'd85;
            2'd2: v = 8'd170;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgbdith_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rgbdith_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rgb222_error_diffusion_dither.sv -----
// rgb888 to rgb222 floyd-steinberg error diffusion dither
// i_pix (sink): one rgb888 pixel per item, raster order, frame size from the
//   frame_width / frame_height registers (apb, byte address 0 and 4)
// o_pix (source): dithered rgb (0/85/170/255 per channel), the 6-bit palette
//   index and a frame_end flag on the last pixel of the frame
// an accepted item is registered in stage 1, then in the output register
// throughput: one item per cycle while o_pix is ready; pixel error feedback
//   and row error ram (one write, one registered read per cycle) keep pace
// row errors live in a two-bank ram, one bank read for the current row and
//   the other written for the next; each slot is written once when all its
//   shares are in, the slot past the row end is held in a register
// reset: registers return to 640 x 480, position to the frame start and all
//   diffused error reads as zero at once (no clearing pass)
// a stall on o_pix holds the output register; the stage in front still takes
//   one more item, then i_pix.ready drops until o_pix drains
// size registers are to be written only while no item is in flight (the
//   block does not enforce this); new sizes take effect on the next pixel
`timescale 1ns / 1ps
`default_nettype none
`include "rgb222_error_diffusion_dither_assert.svh"

module rgb222_error_diffusion_dither #(
    parameter int MAX_WIDTH           = rgbdith_pkg::MAX_WIDTH_DEF,
    parameter int ERROR_FRACTION_BITS = rgbdith_pkg::ERR_FRAC_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rgbdith_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rgbdith_pkg::PDATA_W-1:0]  pwdata,
    output logic      [rgbdith_pkg::PDATA_W-1:0]  prdata,
    output logic                                  pready,
    // pixel channels
    rgbdith_stream_if.sink                        i_pix,
    rgbdith_stream_if.source                      o_pix
);

    localparam int F    = ERROR_FRACTION_BITS;
    localparam int XW   = $clog2(MAX_WIDTH);          // column index
    localparam int AW   = XW + 1;                     // bank + slot
    localparam int EW   = F + 7;                      // stored error
    localparam int SW   = F + 10;                     // pixel plus errors
    localparam int PW   = EW + 3;                     // error times weight
    localparam int DW   = 3 * EW;                     // ram word
    localparam int HW   = rgbdith_pkg::FRAME_DIM_W;
    localparam int RW   = rgbdith_pkg::ROW_W;
    localparam int CMPW = ((XW + 1) > HW) ? (XW + 1) : HW;
    localparam logic signed [SW-1:0] TOP_V = SW'(255 << F);

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_TAIL = 2'd2
    } t_src;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [HW-1:0] r_frame_width;
    logic [HW-1:0] r_frame_height;
    logic          cfg_wr;
    rgbdith_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = rgbdith_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= HW'(rgbdith_pkg::WIDTH_RESET);
            r_frame_height <= HW'(rgbdith_pkg::HEIGHT_RESET);
        end else if (cfg_wr) begin
            case (cfg_idx)
                rgbdith_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[HW-1:0];
                rgbdith_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rgbdith_pkg::REG_FRAME_WIDTH:
                prdata = rgbdith_pkg::PDATA_W'(r_frame_width);
            rgbdith_pkg::REG_FRAME_HEIGHT:
                prdata = rgbdith_pkg::PDATA_W'(r_frame_height);
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake
    // ---------------------------------------------------------------
    logic r_s1_v;
    logic r_o_v;
    logic s1_adv;       // stage 1 moves into the output register
    logic in_acc;
    logic wr_en;

    assign s1_adv      = !r_o_v || o_pix.ready;
    assign i_pix.ready = !r_s1_v || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign wr_en       = r_s1_v && s1_adv;

    // ---------------------------------------------------------------
    // front: frame position, tracked as items are accepted
    // ---------------------------------------------------------------
    logic [XW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_bank;       // bank holding the current row's errors
    logic          r_prev_ok;    // previous row left errors for this row
    logic [XW-1:0] r_prev_last;  // last column of the previous row

    logic [XW:0]     slot;
    logic [CMPW-1:0] w_ext;
    logic [CMPW-1:0] w_eff;
    logic [HW-1:0]   h_eff;
    logic            f_last_col;
    logic            f_last_row;
    t_src            f_src;

    always_comb begin
        slot  = {1'b0, r_col} + 1'b1;
        w_ext = CMPW'(r_frame_width);
        if (w_ext == '0) begin
            w_eff = CMPW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (r_frame_height > HW'(rgbdith_pkg::MAX_HEIGHT)) begin
            h_eff = HW'(rgbdith_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
        f_last_col = CMPW'(slot) >= w_eff;
        f_last_row = (HW'(r_row) + 1'b1) >= h_eff;
        // slot x+1 of the current row: ram up to the previous row end,
        // the held tail slot just past it, zero beyond
        if (r_prev_ok && (slot <= {1'b0, r_prev_last})) begin
            f_src = SRC_MEM;
        end else if (r_prev_ok && (slot == ({1'b0, r_prev_last} + 1'b1))) begin
            f_src = SRC_TAIL;
        end else begin
            f_src = SRC_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_bank      <= 1'b0;
            r_prev_ok   <= 1'b0;
            r_prev_last <= '0;
        end else if (in_acc) begin
            if (!f_last_col) begin
                r_col <= slot[XW-1:0];
            end else if (!f_last_row) begin
                r_col       <= '0;
                r_row       <= r_row + 1'b1;
                r_bank      <= !r_bank;
                r_prev_ok   <= 1'b1;
                r_prev_last <= r_col;
            end else begin
                r_col     <= '0;
                r_row     <= '0;
                r_prev_ok <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // row error ram, two banks, read address issued at accept
    // ---------------------------------------------------------------
    logic [DW-1:0] r_mem [2**AW];
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_word;
    logic [DW-1:0] r_rd_q;

    assign rd_addr = {r_bank, slot[XW-1:0]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (in_acc) begin
            r_rd_q <= r_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // stage 1: accepted pixel with its position and error source
    // ---------------------------------------------------------------
    rgbdith_pkg::t_pix_in r_s1_pix;
    logic [XW-1:0]        r_s1_x;
    logic                 r_s1_last_col;
    logic                 r_s1_last_row;
    logic                 r_s1_bank;
    t_src                 r_s1_src;
    logic                 r_byp_hit;    // ram slot written on the read edge
    logic [DW-1:0]        r_byp_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix      <= i_pix.payload;
            r_s1_x        <= r_col;
            r_s1_last_col <= f_last_col;
            r_s1_last_row <= f_last_row;
            r_s1_bank     <= r_bank;
            r_s1_src      <= f_src;
            r_byp_hit     <= wr_en && (wr_addr == rd_addr);
            r_byp_data    <= wr_word;
        end
    end

    // ---------------------------------------------------------------
    // per channel quantize and diffuse
    // ---------------------------------------------------------------
    logic signed [EW-1:0] r_right [3];
    logic signed [EW-1:0] r_pend0 [3];   // next-row slot x+1, partial
    logic signed [EW-1:0] r_pend1 [3];   // next-row slot x+2, partial
    logic signed [EW-1:0] r_tail  [3];   // next-row slot past the row end

    logic [DW-1:0]        rd_word;
    logic [7:0]           pix_c   [3];
    logic signed [EW-1:0] this_e  [3];
    logic signed [SW-1:0] v_sum   [3];
    logic signed [SW-1:0] v_clip  [3];
    logic [1:0]           lvl     [3];
    logic signed [SW-1:0] e_full  [3];
    logic signed [EW-1:0] err     [3];
    logic signed [PW-1:0] p_one   [3];
    logic signed [PW-1:0] p7      [3];
    logic signed [PW-1:0] p3      [3];
    logic signed [PW-1:0] p5      [3];
    logic signed [PW-1:0] q7      [3];
    logic signed [PW-1:0] q3      [3];
    logic signed [PW-1:0] q5      [3];
    logic signed [PW-1:0] q1      [3];
    logic signed [EW-1:0] s7      [3];
    logic signed [EW-1:0] s3      [3];
    logic signed [EW-1:0] s5      [3];
    logic signed [EW-1:0] s1      [3];
    logic signed [EW-1:0] n_right [3];
    logic signed [EW-1:0] n_pend0 [3];
    logic signed [EW-1:0] n_pend1 [3];
    logic signed [EW-1:0] n_tail  [3];
    logic                 down_ok;

    assign rd_word  = r_byp_hit ? r_byp_data : r_rd_q;
    assign pix_c[0] = r_s1_pix.red_in;
    assign pix_c[1] = r_s1_pix.green_in;
    assign pix_c[2] = r_s1_pix.blue_in;
    assign wr_addr  = {!r_s1_bank, r_s1_x};
    assign down_ok  = !r_s1_last_row;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r_s1_src)
                SRC_MEM:  this_e[c] = rd_word[c*EW +: EW];
                SRC_TAIL: this_e[c] = r_tail[c];
                default:  this_e[c] = '0;
            endcase
            v_sum[c] = $signed({{(SW - 8 - F){1'b0}}, pix_c[c], {F{1'b0}}})
                       + SW'(this_e[c]) + SW'(r_right[c]);
            if (v_sum[c] < 0) begin
                v_clip[c] = '0;
            end else if (v_sum[c] > TOP_V) begin
                v_clip[c] = TOP_V;
            end else begin
                v_clip[c] = v_sum[c];
            end
            lvl[c]    = rgbdith_pkg::level_of(v_clip[c][F +: 8]);
            e_full[c] = v_clip[c] - $signed({{(SW - 8 - F){1'b0}},
                        rgbdith_pkg::level_value(lvl[c]), {F{1'b0}}});
            err[c]    = e_full[c][EW-1:0];

            // weights 7, 3, 5, 1 by shift and add, floor divide by 16
            p_one[c] = PW'(err[c]);
            p7[c]    = (p_one[c] <<< 3) - p_one[c];
            p3[c]    = (p_one[c] <<< 1) + p_one[c];
            p5[c]    = (p_one[c] <<< 2) + p_one[c];
            q7[c]    = p7[c] >>> 4;
            q3[c]    = p3[c] >>> 4;
            q5[c]    = p5[c] >>> 4;
            q1[c]    = p_one[c] >>> 4;
            s7[c]    = q7[c][EW-1:0];
            s3[c]    = (down_ok && (r_s1_x != '0)) ? q3[c][EW-1:0] : '0;
            s5[c]    = down_ok ? q5[c][EW-1:0] : '0;
            s1[c]    = (down_ok && !r_s1_last_col) ? q1[c][EW-1:0] : '0;

            // slot x of the next row is complete with this pixel's share
            wr_word[c*EW +: EW] = r_pend0[c] + s3[c];
            n_tail[c]  = r_pend1[c] + s5[c];
            n_right[c] = r_s1_last_col ? '0 : s7[c];
            n_pend0[c] = r_s1_last_col ? '0 : n_tail[c];
            n_pend1[c] = r_s1_last_col ? '0 : s1[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_right[c] <= '0;
                r_pend0[c] <= '0;
                r_pend1[c] <= '0;
            end
        end else if (wr_en) begin
            for (int c = 0; c < 3; c++) begin
                r_right[c] <= n_right[c];
                r_pend0[c] <= n_pend0[c];
                r_pend1[c] <= n_pend1[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_s1_last_col) begin
            for (int c = 0; c < 3; c++) begin
                r_tail[c] <= n_tail[c];
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    rgbdith_pkg::t_pix_out r_o_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_adv) begin
            r_o_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_o_pay.red_out       <= rgbdith_pkg::level_value(lvl[0]);
            r_o_pay.green_out     <= rgbdith_pkg::level_value(lvl[1]);
            r_o_pay.blue_out      <= rgbdith_pkg::level_value(lvl[2]);
            r_o_pay.palette_index <= {lvl[0], lvl[1], lvl[2]};
            r_o_pay.frame_end     <= r_s1_last_col && r_s1_last_row;
        end
    end

    assign o_pix.valid   = r_o_v;
    assign o_pix.payload = r_o_pay;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // palette index agrees with the expanded channel values
    `RGBDITH_ASSERT_IMP(a_palette_match, i_clk, i_rst_n, r_o_v,
        (r_o_pay.red_out == rgbdith_pkg::level_value(r_o_pay.palette_index[5:4]))
        && (r_o_pay.green_out == rgbdith_pkg::level_value(r_o_pay.palette_index[3:2]))
        && (r_o_pay.blue_out == rgbdith_pkg::level_value(r_o_pay.palette_index[1:0])))

    // last pixel of a frame sends the position back to the start
    `RGBDITH_ASSERT_NXT(a_frame_wrap, i_clk, i_rst_n, in_acc && f_last_col && f_last_row,
        (r_col == '0) && (r_row == '0) && !r_prev_ok)

    // a row starts with no carried error
    `RGBDITH_ASSERT_IMP(a_row_start_clear, i_clk, i_rst_n, r_s1_v && (r_s1_x == '0),
        (r_right[0] == '0) && (r_right[1] == '0) && (r_right[2] == '0)
        && (r_pend0[0] == '0) && (r_pend0[1] == '0) && (r_pend0[2] == '0)
        && (r_pend1[0] == '0) && (r_pend1[1] == '0) && (r_pend1[2] == '0))

    // a ram read can only collide with a write at the first pixel of a row
    `RGBDITH_ASSERT_IMP(a_bypass_row_start, i_clk, i_rst_n, r_s1_v && r_byp_hit,
        (r_s1_x == '0) && (r_s1_src == SRC_MEM))

endmodule

`default_nettype wire

// ----- dv/rgb222_error_diffusion_dither_tb.sv -----
`timescale 1ns / 1ps

module rgb222_error_diffusion_dither_tb;

    localparam int FRAC      = rgbdith_pkg::ERR_FRAC_DEF;
    localparam int WIDTH_CAP = rgbdith_pkg::MAX_WIDTH_DEF;
    localparam int SLOTS     = rgbdith_pkg::MAX_WIDTH_DEF + 2;
    localparam int ADDR_W    = rgbdith_pkg::PADDR_W;
    localparam int DATA_W    = rgbdith_pkg::PDATA_W;
    localparam int RANDOM_ITEMS = 1250;

    // clock, reset and configuration port inputs, all known from time zero
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [ADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // pixel channel drive
    logic                 in_valid   = 1'b0;
    rgbdith_pkg::t_pix_in in_payload = '0;
    logic                 out_ready  = 1'b0;
    bit                   steady     = 1'b0;

    rgbdith_stream_if #(.t_payload(rgbdith_pkg::t_pix_in))  pix_in_if ();
    rgbdith_stream_if #(.t_payload(rgbdith_pkg::t_pix_out)) pix_out_if ();

    assign pix_in_if.valid   = in_valid;
    assign pix_in_if.payload = in_payload;
    assign pix_out_if.ready  = out_ready;

    rgb222_error_diffusion_dither u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_in_if.sink),
        .o_pix   (pix_out_if.source)
    );

    always #5 i_clk = ~i_clk;

    // dither state as the block should hold it
    int cfg_width  = rgbdith_pkg::WIDTH_RESET;
    int cfg_height = rgbdith_pkg::HEIGHT_RESET;
    int col_pos    = 0;
    int row_pos    = 0;
    int right_err [3];
    int row_err_cur [3][SLOTS];
    int row_err_nxt [3][SLOTS];

    // pixels waiting to be driven, and dithered pixels waiting to come out
    rgbdith_pkg::t_pix_in  pixel_backlog [$];
    rgbdith_pkg::t_pix_out expected_pixels [$];
    int pixels_pushed  = 0;
    int pixels_taken   = 0;
    int mismatch_count = 0;

    // dither one pixel and advance the raster position
    function automatic rgbdith_pkg::t_pix_out dither_pixel(input rgbdith_pkg::t_pix_in px);
        int w, h, x, v, err, t;
        int lvl [3];
        int chan [3];
        bit last_col, last_row;
        rgbdith_pkg::t_pix_out r;
        w = cfg_width;
        h = cfg_height;
        // zero acts as one, oversize saturates
        if (w == 0) w = 1;
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        if (h == 0) h = 1;
        if (h > rgbdith_pkg::MAX_HEIGHT) h = rgbdith_pkg::MAX_HEIGHT;
        x = col_pos;
        if (x >= WIDTH_CAP) x = WIDTH_CAP - 1;
        // a position at or past a shrunk size counts as the last one
        last_col = (x + 1 >= w);
        last_row = (row_pos + 1 >= h);
        chan[0] = int'(px.red_in);
        chan[1] = int'(px.green_in);
        chan[2] = int'(px.blue_in);
        for (int c = 0; c < 3; c++) begin
            v = (chan[c] << FRAC) + row_err_cur[c][x + 1] + right_err[c];
            if (v < 0) v = 0;
            if (v > (255 << FRAC)) v = 255 << FRAC;
            t = v >>> FRAC;
            if (t < int'(rgbdith_pkg::LVL_T1)) lvl[c] = 0;
            else if (t < int'(rgbdith_pkg::LVL_T2)) lvl[c] = 1;
            else if (t < int'(rgbdith_pkg::LVL_T3)) lvl[c] = 2;
            else lvl[c] = 3;
            err = v - ((lvl[c] * 85) << FRAC);
            // each share floors on its own, so they need not sum to err
            right_err[c] = last_col ? 0 : (err * 7) >>> 4;
            if (!last_row) begin
                if (x >= 1) row_err_nxt[c][x] += (err * 3) >>> 4;
                row_err_nxt[c][x + 1] += (err * 5) >>> 4;
                if (!last_col) row_err_nxt[c][x + 2] += err >>> 4;
            end
        end
        r.red_out       = 8'(lvl[0] * 85);
        r.green_out     = 8'(lvl[1] * 85);
        r.blue_out      = 8'(lvl[2] * 85);
        r.palette_index = 6'((lvl[0] << 4) | (lvl[1] << 2) | lvl[2]);
        r.frame_end     = last_col && last_row;
        if (!last_col) begin
            col_pos = x + 1;
        end else if (!last_row) begin
            // row end: gathered row moves up
            col_pos = 0;
            row_pos++;
            row_err_cur = row_err_nxt;
            foreach (row_err_nxt[c, i]) row_err_nxt[c][i] = 0;
            foreach (right_err[c]) right_err[c] = 0;
        end else begin
            // frame end: everything starts over
            col_pos = 0;
            row_pos = 0;
            foreach (row_err_nxt[c, i]) row_err_nxt[c][i] = 0;
            foreach (row_err_cur[c, i]) row_err_cur[c][i] = 0;
            foreach (right_err[c]) right_err[c] = 0;
        end
        return r;
    endfunction

    // pixel driver: holds valid until taken, idles now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && pix_in_if.ready) begin
                expected_pixels.push_back(dither_pixel(in_payload));
                pixels_taken++;
            end
            if (!in_valid || pix_in_if.ready) begin
                if (pixel_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
                    in_valid   <= 1'b1;
                    in_payload <= pixel_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin : monitor
        rgbdith_pkg::t_pix_out got, want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (pix_out_if.valid && out_ready) begin
                got = pix_out_if.payload;
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected item: rgb %0d %0d %0d idx %0d end %0d",
                                 got.red_out, got.green_out, got.blue_out,
                                 got.palette_index, got.frame_end);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                        got.blue_out !== want.blue_out ||
                        got.palette_index !== want.palette_index ||
                        got.frame_end !== want.frame_end) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %0d %0d %0d i%0d e%0d got %0d %0d %0d i%0d e%0d",
                                     want.red_out, want.green_out, want.blue_out,
                                     want.palette_index, want.frame_end,
                                     got.red_out, got.green_out, got.blue_out,
                                     got.palette_index, got.frame_end);
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        rgbdith_pkg::t_pix_in px;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        pixel_backlog.push_back(px);
        pixels_pushed++;
    endtask

    // block is idle once every pixel is taken and every result is out
    task automatic wait_idle();
        while (pixels_taken < pixels_pushed || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup then access, register lands when pready is high
    task automatic reg_write(input rgbdith_pkg::t_reg_idx idx, input int val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rgbdith_pkg::REG_FRAME_WIDTH) cfg_width = val & 'h7FF;
        else cfg_height = val & 'h7FF;
    endtask

    initial begin : stimulus
        int phase, mode, w, h, n, style, random_sent;
        logic [7:0] base_r, base_g, base_b;
        random_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry 640 x 480: extremes and quantizer thresholds
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd42, 8'd43, 8'd127);
        push_pixel(8'd128, 8'd212, 8'd213);
        push_pixel(8'd255, 8'd0, 8'd128);
        push_pixel(8'd0, 8'd255, 8'd42);
        push_pixel(8'd213, 8'd127, 8'd43);
        push_pixel(8'd212, 8'd128, 8'd0);
        push_pixel(8'd1, 8'd254, 8'd85);
        push_pixel(8'd170, 8'd85, 8'd170);
        push_pixel(8'd128, 8'd128, 8'd128);
        push_pixel(8'd255, 8'd255, 8'd0);
        wait_idle();

        // zero size mid-frame: acts as 1 x 1, every pixel ends a frame
        reg_write(rgbdith_pkg::REG_FRAME_WIDTH, 0);
        reg_write(rgbdith_pkg::REG_FRAME_HEIGHT, 0);
        push_pixel(8'd255, 8'd0, 8'd255);
        push_pixel(8'd42, 8'd213, 8'd127);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd200, 8'd100, 8'd50);
        wait_idle();

        // 3 x 2 flat field: row end, frame end, start of the next frame
        reg_write(rgbdith_pkg::REG_FRAME_WIDTH, 3);
        reg_write(rgbdith_pkg::REG_FRAME_HEIGHT, 2);
        repeat (8) push_pixel(8'd100, 8'd150, 8'd30);
        wait_idle();

        // random phases, each with its own geometry
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase == 0) begin
                w = 1024;
                h = 1;
                n = $urandom_range(60, 200);
            end else if (phase == 1) begin
                // oversize on both registers
                w = 2047;
                h = 2047;
                n = $urandom_range(60, 200);
            end else if (phase == 2) begin
                w = 1;
                h = 1024;
                n = $urandom_range(30, 80);
            end else begin
                mode = $urandom_range(0, 19);
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
                if (mode == 0) begin
                    w = 0;
                end else if (mode == 1) begin
                    h = 0;
                    n = w * $urandom_range(1, 4);
                end else if (mode == 2) begin
                    // wide rows, partial frame so a later phase shrinks it
                    w = $urandom_range(1000, 2047);
                    h = $urandom_range(1, 2);
                    n = $urandom_range(30, 150);
                end
            end
            // a long run of phases with both sides always willing
            steady = (phase >= 6 && phase < 12);
            reg_write(rgbdith_pkg::REG_FRAME_WIDTH, w);
            reg_write(rgbdith_pkg::REG_FRAME_HEIGHT, h);
            style  = $urandom_range(0, 1);
            base_r = 8'($urandom_range(0, 255));
            base_g = 8'($urandom_range(0, 255));
            base_b = 8'($urandom_range(0, 255));
            for (int i = 0; i < n; i++) begin
                if (style == 0)
                    push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                else
                    // near-flat field, where dithering patterns show
                    push_pixel(base_r ^ 8'($urandom_range(0, 7)),
                               base_g ^ 8'($urandom_range(0, 7)),
                               base_b ^ 8'($urandom_range(0, 7)));
            end
            random_sent += n;
            wait_idle();
            phase++;
        end
        steady = 1'b0;

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rgbdith_pkg.sv
rtl/core/rgbdith_stream_if.sv
rtl/core/rgb222_error_diffusion_dither.sv
dv/rgb222_error_diffusion_dither_tb.sv
